/* rtl/grid_traversability_inflation_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the grid traversability inflation unit
// Clocked on clk, disabled while arst_n is low. Define NO_ASSERTIONS to drop.
// ----------------------------------------------------------------------------
`ifndef GRID_TRAVERSABILITY_INFLATION_UNIT_MACROS_SVH
`define GRID_TRAVERSABILITY_INFLATION_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define GTI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
`define GTI_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) \
		else $error(msg);
`else
`define GTI_ASSERT(label, prop, msg)
`define GTI_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

/* rtl/gti_pkg.sv */
// ----------------------------------------------------------------------------
// gti_pkg
// Shared types and constants of the grid traversability inflation unit.
// ----------------------------------------------------------------------------
package gti_pkg;

	localparam int DEF_MAX_BLOCK_ROWS = 16;
	localparam int DEF_MAX_BLOCK_COLS = 16;
	localparam logic [3:0] MAX_SUB_CELLS = 4'd8;

	localparam int CFG_AW = 5;

	localparam logic [2:0] REG_BLOCK_ROWS     = 3'd0;
	localparam logic [2:0] REG_BLOCK_COLS     = 3'd1;
	localparam logic [2:0] REG_SUB_ROWS       = 3'd2;
	localparam logic [2:0] REG_SUB_COLS       = 3'd3;
	localparam logic [2:0] REG_INFLATE_ALONG  = 3'd4;
	localparam logic [2:0] REG_INFLATE_ACROSS = 3'd5;
	localparam logic [2:0] REG_CLEANABLE      = 3'd6;

	localparam logic [2:0] ST_FREE              = 3'd0;
	localparam logic [2:0] ST_OBSTACLE          = 3'd1;
	localparam logic [2:0] ST_MISSING_CELL      = 3'd2;
	localparam logic [2:0] ST_BOUNDARY          = 3'd3;
	localparam logic [2:0] ST_MISSING_INFLATION = 3'd4;
	localparam logic [2:0] ST_UNKNOWN           = 3'd5;

	typedef struct packed {
		logic [4:0] block_rows;
		logic [4:0] block_cols;
		logic [3:0] sub_rows;
		logic [3:0] sub_cols;
		logic [5:0] inflate_along_cells;
		logic [5:0] inflate_across_cells;
		logic       block_cleanable;
	} cfg_t;

endpackage

/* rtl/gti_ram.sv */
// ----------------------------------------------------------------------------
// gti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gti_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/gti_cfg.sv */
// ----------------------------------------------------------------------------
// gti_cfg
// APB register file holding block geometry, inflation counts and cleanable.
// ----------------------------------------------------------------------------
module gti_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [gti_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output gti_pkg::cfg_t             cfg
);
	import gti_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;

	assign reg_idx = paddr[CFG_AW-1:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_rows           <= 5'd1;
			cfg_q.block_cols           <= 5'd1;
			cfg_q.sub_rows             <= 4'd1;
			cfg_q.sub_cols             <= 4'd1;
			cfg_q.inflate_along_cells  <= 6'd0;
			cfg_q.inflate_across_cells <= 6'd0;
			cfg_q.block_cleanable      <= 1'b1;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_BLOCK_ROWS:     cfg_q.block_rows           <= pwdata[4:0];
				REG_BLOCK_COLS:     cfg_q.block_cols           <= pwdata[4:0];
				REG_SUB_ROWS:       cfg_q.sub_rows             <= pwdata[3:0];
				REG_SUB_COLS:       cfg_q.sub_cols             <= pwdata[3:0];
				REG_INFLATE_ALONG:  cfg_q.inflate_along_cells  <= pwdata[5:0];
				REG_INFLATE_ACROSS: cfg_q.inflate_across_cells <= pwdata[5:0];
				REG_CLEANABLE:      cfg_q.block_cleanable      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BLOCK_ROWS:     prdata = 32'(cfg_q.block_rows);
			REG_BLOCK_COLS:     prdata = 32'(cfg_q.block_cols);
			REG_SUB_ROWS:       prdata = 32'(cfg_q.sub_rows);
			REG_SUB_COLS:       prdata = 32'(cfg_q.sub_cols);
			REG_INFLATE_ALONG:  prdata = 32'(cfg_q.inflate_along_cells);
			REG_INFLATE_ACROSS: prdata = 32'(cfg_q.inflate_across_cells);
			REG_CLEANABLE:      prdata = 32'(cfg_q.block_cleanable);
			default:            prdata = 32'd0;
		endcase
	end

endmodule

/* rtl/gti_seq.sv */
// ----------------------------------------------------------------------------
// gti_seq
// Query sequencer: range/cleanable/cell/boundary checks, window extent search
// on one shared add/compare unit, then a serial walk over the coarse cells.
// ----------------------------------------------------------------------------
`include "grid_traversability_inflation_unit_macros.svh"

module gti_seq #(
	parameter int MAX_BLOCK_ROWS = gti_pkg::DEF_MAX_BLOCK_ROWS,
	parameter int MAX_BLOCK_COLS = gti_pkg::DEF_MAX_BLOCK_COLS,
	localparam int DEPTH = MAX_BLOCK_ROWS * MAX_BLOCK_COLS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  gti_pkg::cfg_t cfg,
	input  logic          start,
	input  logic          kind,
	input  logic [3:0]    coarse_row,
	input  logic [3:0]    coarse_col,
	input  logic          present,
	input  logic [2:0]    fine_row,
	input  logic [2:0]    fine_col,
	input  logic [1:0]    heading,
	output logic          busy,
	output logic          done,
	output logic [2:0]    status,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic          mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  logic          mem_rdata
);
	import gti_pkg::*;

	localparam int MW = AW + 6;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_PREP   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_EXT    = 3'd4;
	localparam logic [2:0] S_SRD    = 3'd5;
	localparam logic [2:0] S_SCHK   = 3'd6;

	localparam logic [1:0] DIR_ROW_LO = 2'd0;
	localparam logic [1:0] DIR_ROW_HI = 2'd1;
	localparam logic [1:0] DIR_COL_LO = 2'd2;
	localparam logic [1:0] DIR_COL_HI = 2'd3;

	function automatic logic [AW-1:0] map_addr(input logic [4:0] row, input logic [4:0] col);
		logic [MW-1:0] lin;
		lin = MW'(row) * MW'(MAX_BLOCK_COLS) + MW'(col);
		return lin[AW-1:0];
	endfunction

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic          done_q;
	logic [2:0]    status_q;
	logic [4:0]    row_q, col_q;
	logic [2:0]    ri_q, ci_q;
	logic          axis_v_q;
	logic          unk_q;
	logic [7:0]    gr_q, gc_q, tr_q, tc_q;
	logic [1:0]    dir_q;
	logic [6:0]    acc_q;
	logic [5:0]    k_q;
	logic [4:0]    row_lo_q, row_hi_q, col_lo_q, col_hi_q;

	logic [4:0] rows_c, cols_c;
	logic [3:0] sr_c, sc_c;
	logic [5:0] iu, iv;
	logic       unk;
	logic       bnd;
	logic [5:0] ext_lim;
	logic [3:0] ext_step;
	logic [4:0] ext_base;
	logic       ext_done;
	logic [4:0] ext_lo, ext_hi;
	logic [6:0] init_next;
	logic       wr_in_map;
	logic       decides;
	logic       scan_in_win;

	always_comb begin
		rows_c = (9'(cfg.block_rows) > 9'(MAX_BLOCK_ROWS)) ? 5'(MAX_BLOCK_ROWS) : cfg.block_rows;
		cols_c = (9'(cfg.block_cols) > 9'(MAX_BLOCK_COLS)) ? 5'(MAX_BLOCK_COLS) : cfg.block_cols;
		sr_c   = (cfg.sub_rows > MAX_SUB_CELLS) ? MAX_SUB_CELLS : cfg.sub_rows;
		sc_c   = (cfg.sub_cols > MAX_SUB_CELLS) ? MAX_SUB_CELLS : cfg.sub_cols;
		iu     = axis_v_q ? cfg.inflate_across_cells : cfg.inflate_along_cells;
		iv     = axis_v_q ? cfg.inflate_along_cells : cfg.inflate_across_cells;
	end

	always_comb begin
		unk = (rows_c == 5'd0) || (cols_c == 5'd0) || (sr_c == 4'd0) || (sc_c == 4'd0)
			|| (row_q >= rows_c) || (col_q >= cols_c)
			|| (4'(ri_q) >= sr_c) || (4'(ci_q) >= sc_c);
		bnd = (9'(gc_q) < 9'(iu)) || ((9'(gc_q) + 9'(iu)) >= 9'(tc_q))
			|| (9'(gr_q) < 9'(iv)) || ((9'(gr_q) + 9'(iv)) >= 9'(tr_q));
	end

	// shared add/compare unit for the four window extents
	always_comb begin
		ext_lim  = dir_q[1] ? iu : iv;
		ext_step = dir_q[1] ? sc_c : sr_c;
		ext_base = dir_q[1] ? col_q : row_q;
		ext_done = acc_q >= 7'(ext_lim);
		ext_lo   = 5'(6'(ext_base) - k_q);
		ext_hi   = 5'(6'(ext_base) + k_q);
		unique case (dir_q)
			DIR_ROW_LO: init_next = 7'(sr_c - 4'd1 - 4'(ri_q));
			DIR_ROW_HI: init_next = 7'(ci_q);
			DIR_COL_LO: init_next = 7'(sc_c - 4'd1 - 4'(ci_q));
			DIR_COL_HI: init_next = 7'd0;
		endcase
	end

	always_comb begin
		wr_in_map = (9'(coarse_row) < 9'(MAX_BLOCK_ROWS)) && (9'(coarse_col) < 9'(MAX_BLOCK_COLS));
		mem_we    = (state_q == S_CLEAR) || ((state_q == S_IDLE) && start && !kind && wr_in_map);
		mem_waddr = (state_q == S_CLEAR) ? clr_q : map_addr(5'(coarse_row), 5'(coarse_col));
		mem_wdata = (state_q == S_CLEAR) ? 1'b0 : present;
		mem_raddr = map_addr(row_q, col_q);
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;

	assign decides     = (state_q == S_DECIDE) || (state_q == S_SCHK);
	assign scan_in_win = (row_q >= row_lo_q) && (row_q <= row_hi_q)
		&& (col_q >= col_lo_q) && (col_q <= col_hi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			done_q   <= 1'b0;
			status_q <= ST_FREE;
			row_q    <= '0;
			col_q    <= '0;
			ri_q     <= '0;
			ci_q     <= '0;
			axis_v_q <= 1'b0;
			unk_q    <= 1'b0;
			gr_q     <= '0;
			gc_q     <= '0;
			tr_q     <= '0;
			tc_q     <= '0;
			dir_q    <= DIR_ROW_LO;
			acc_q    <= '0;
			k_q      <= '0;
			row_lo_q <= '0;
			row_hi_q <= '0;
			col_lo_q <= '0;
			col_hi_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (start && kind) begin
						row_q    <= 5'(coarse_row);
						col_q    <= 5'(coarse_col);
						ri_q     <= fine_row;
						ci_q     <= fine_col;
						axis_v_q <= heading[1];
						state_q  <= S_PREP;
					end
				end
				S_PREP: begin
					unk_q   <= unk;
					gr_q    <= 8'(row_q) * 8'(sr_c) + 8'(ri_q);
					gc_q    <= 8'(col_q) * 8'(sc_c) + 8'(ci_q);
					tr_q    <= 8'(rows_c) * 8'(sr_c);
					tc_q    <= 8'(cols_c) * 8'(sc_c);
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (unk_q) begin
						done_q   <= 1'b1;
						status_q <= ST_UNKNOWN;
						state_q  <= S_IDLE;
					end else if (!cfg.block_cleanable) begin
						done_q   <= 1'b1;
						status_q <= ST_OBSTACLE;
						state_q  <= S_IDLE;
					end else if (!mem_rdata) begin
						done_q   <= 1'b1;
						status_q <= ST_MISSING_CELL;
						state_q  <= S_IDLE;
					end else if (bnd) begin
						done_q   <= 1'b1;
						status_q <= ST_BOUNDARY;
						state_q  <= S_IDLE;
					end else begin
						dir_q   <= DIR_ROW_LO;
						acc_q   <= 7'(ri_q);
						k_q     <= '0;
						state_q <= S_EXT;
					end
				end
				S_EXT: begin
					if (ext_done) begin
						unique case (dir_q)
							DIR_ROW_LO: row_lo_q <= ext_lo;
							DIR_ROW_HI: row_hi_q <= ext_hi;
							DIR_COL_LO: col_lo_q <= ext_lo;
							DIR_COL_HI: col_hi_q <= ext_hi;
						endcase
						if (dir_q == DIR_COL_HI) begin
							row_q   <= row_lo_q;
							col_q   <= col_lo_q;
							state_q <= S_SRD;
						end else begin
							dir_q <= dir_q + 2'd1;
							acc_q <= init_next;
							k_q   <= '0;
						end
					end else begin
						acc_q <= acc_q + 7'(ext_step);
						k_q   <= k_q + 6'd1;
					end
				end
				S_SRD: begin
					state_q <= S_SCHK;
				end
				S_SCHK: begin
					if (!mem_rdata) begin
						done_q   <= 1'b1;
						status_q <= ST_MISSING_INFLATION;
						state_q  <= S_IDLE;
					end else if (col_q == col_hi_q) begin
						if (row_q == row_hi_q) begin
							done_q   <= 1'b1;
							status_q <= ST_FREE;
							state_q  <= S_IDLE;
						end else begin
							row_q   <= row_q + 5'd1;
							col_q   <= col_lo_q;
							state_q <= S_SRD;
						end
					end else begin
						col_q   <= col_q + 5'd1;
						state_q <= S_SRD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`GTI_ASSERT_NEXT(a_done_source, !decides, !done_q, "result word outside a decision step")
	`GTI_ASSERT(a_scan_window, (state_q == S_SRD) |-> scan_in_win, "scan left the window")
	`GTI_ASSERT_NEXT(a_write_silent, start && !busy && !kind, !done_q, "write produced a result word")

endmodule

/* rtl/grid_traversability_inflation_unit.sv */
// ----------------------------------------------------------------------------
// grid_traversability_inflation_unit
// Presence map of coarse cells with heading-dependent obstacle inflation query.
// ----------------------------------------------------------------------------
// After reset the presence map is swept clear, one entry per cycle, over all
// MAX_BLOCK_ROWS*MAX_BLOCK_COLS entries with busy high; configuration writes
// are taken throughout. A write word is taken while idle and busy stays low. A
// query word passes S_PREP, then S_DECIDE returns its status on done when it
// ends at the range, cleanable, cell or boundary check; otherwise the shared
// add/compare unit searches the four window edges, one step per cycle, and
// then the coarse cells of the window are read from the map, each cell read
// in S_SRD and checked in S_SCHK, stopping at the first absent one. done is
// high for exactly one cycle and cannot be held off, so the receiver must
// take status then.
module grid_traversability_inflation_unit #(
	parameter int MAX_BLOCK_ROWS = gti_pkg::DEF_MAX_BLOCK_ROWS,
	parameter int MAX_BLOCK_COLS = gti_pkg::DEF_MAX_BLOCK_COLS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gti_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       start,
	output logic                       busy,
	input  logic                       kind,
	input  logic [3:0]                 coarse_row,
	input  logic [3:0]                 coarse_col,
	input  logic                       present,
	input  logic [2:0]                 fine_row,
	input  logic [2:0]                 fine_col,
	input  logic [1:0]                 heading,
	output logic                       done,
	output logic [2:0]                 status
);
	import gti_pkg::*;

	localparam int DEPTH = MAX_BLOCK_ROWS * MAX_BLOCK_COLS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cfg_t          cfg;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic          mem_rdata;

	gti_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gti_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	gti_seq #(
		.MAX_BLOCK_ROWS (MAX_BLOCK_ROWS),
		.MAX_BLOCK_COLS (MAX_BLOCK_COLS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.start      (start),
		.kind       (kind),
		.coarse_row (coarse_row),
		.coarse_col (coarse_col),
		.present    (present),
		.fine_row   (fine_row),
		.fine_col   (fine_col),
		.heading    (heading),
		.busy       (busy),
		.done       (done),
		.status     (status),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

endmodule

/* tb/sv/grid_traversability_inflation_unit_test.sv */
// ----------------------------------------------------------------------------
// grid_traversability_inflation_unit_test
// Self-checking bench for the occupancy grid inflation unit. Words go in on
// the start/busy handshake and registers over the APB port. Each accepted
// query is scored by an in-bench occupancy model: range, cleanable, cell,
// boundary band and inflation window checks. Every done pulse is compared
// with the oldest pending status. Directed cases cover the defaults, each
// status, capped and zero geometry and a full-grid window. Random phases
// follow with varied geometry, idle gaps and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_traversability_inflation_unit_test;
	import gti_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 50;

	typedef struct {
		logic [2:0] status;
		logic [3:0] cr;
		logic [3:0] cc;
		logic [2:0] ir;
		logic [2:0] ic;
		logic [1:0] hd;
	} query_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [CFG_AW-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                start;
	logic                busy;
	logic                kind;
	logic [3:0]          coarse_row;
	logic [3:0]          coarse_col;
	logic                present;
	logic [2:0]          fine_row;
	logic [2:0]          fine_col;
	logic [1:0]          heading;
	logic                done;
	logic [2:0]          status;

	cfg_t                cfg_shadow;
	bit                  occupancy [0:15][0:15];
	query_t              pending_status [$];
	int                  failures;
	int                  cycle_count;
	int                  writes_sent;
	int                  queries_sent;
	int                  status_seen [0:7];
	bit                  no_idle;

	grid_traversability_inflation_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.coarse_row (coarse_row),
		.coarse_col (coarse_col),
		.present    (present),
		.fine_row   (fine_row),
		.fine_col   (fine_col),
		.heading    (heading),
		.done       (done),
		.status     (status)
	);

	always #10 clk = ~clk;

	function automatic int capped(input int v, input int hi);
		return (v > hi) ? hi : v;
	endfunction

	function automatic logic [2:0] predict_status(input logic [3:0] cr, input logic [3:0] cc,
			input logic [2:0] ir, input logic [2:0] ic, input logic [1:0] hd);
		int rows, cols, sr, sc, iu, iv, gr, gc, tr, tc, dr, dc, nr, nc;
		rows = capped(int'(cfg_shadow.block_rows), DEF_MAX_BLOCK_ROWS);
		cols = capped(int'(cfg_shadow.block_cols), DEF_MAX_BLOCK_COLS);
		sr = capped(int'(cfg_shadow.sub_rows), int'(MAX_SUB_CELLS));
		sc = capped(int'(cfg_shadow.sub_cols), int'(MAX_SUB_CELLS));
		if (rows == 0 || cols == 0 || sr == 0 || sc == 0)
			return ST_UNKNOWN;
		if (int'(cr) >= rows || int'(cc) >= cols || int'(ir) >= sr || int'(ic) >= sc)
			return ST_UNKNOWN;
		if (!cfg_shadow.block_cleanable)
			return ST_OBSTACLE;
		if (!occupancy[cr][cc])
			return ST_MISSING_CELL;
		if (hd < 2) begin
			iu = int'(cfg_shadow.inflate_along_cells);
			iv = int'(cfg_shadow.inflate_across_cells);
		end else begin
			iu = int'(cfg_shadow.inflate_across_cells);
			iv = int'(cfg_shadow.inflate_along_cells);
		end
		gr = int'(cr) * sr + int'(ir);
		gc = int'(cc) * sc + int'(ic);
		tr = rows * sr;
		tc = cols * sc;
		if (gc < iu || gc >= tc - iu || gr < iv || gr >= tr - iv)
			return ST_BOUNDARY;
		for (dr = -iv; dr <= iv; dr++) begin
			for (dc = -iu; dc <= iu; dc++) begin
				nr = gr + dr;
				nc = gc + dc;
				if (nr >= 0 && nc >= 0 && nr < tr && nc < tc) begin
					if (!occupancy[nr / sr][nc / sc])
						return ST_MISSING_INFLATION;
				end
			end
		end
		return ST_FREE;
	endfunction

	// one word on the start/busy handshake; start stays high on return
	task automatic send_word(input logic k, input logic [3:0] cr, input logic [3:0] cc,
			input logic p, input logic [2:0] ir, input logic [2:0] ic, input logic [1:0] hd);
		int gap;
		query_t q;
		gap = 0;
		if (!no_idle && $urandom_range(99) < 24)
			gap = ($urandom_range(3) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind       <= k;
		coarse_row <= cr;
		coarse_col <= cc;
		present    <= p;
		fine_row   <= ir;
		fine_col   <= ic;
		heading    <= hd;
		start      <= 1'b1;
		do @(posedge clk); while (busy);
		if (k == 1'b0) begin
			occupancy[cr][cc] = p;
			writes_sent++;
		end else begin
			q.status = predict_status(cr, cc, ir, ic, hd);
			q.cr = cr;
			q.cc = cc;
			q.ir = ir;
			q.ic = ic;
			q.hd = hd;
			pending_status.push_back(q);
			queries_sent++;
		end
	endtask

	task automatic write_cell(input logic [3:0] cr, input logic [3:0] cc, input logic p);
		send_word(1'b0, cr, cc, p, 3'($urandom), 3'($urandom), 2'($urandom));
	endtask

	task automatic query_cell(input logic [3:0] cr, input logic [3:0] cc,
			input logic [2:0] ir, input logic [2:0] ic, input logic [1:0] hd);
		send_word(1'b1, cr, cc, 1'($urandom), ir, ic, hd);
	endtask

	task automatic stop_words();
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_results();
		while (pending_status.size() != 0) @(posedge clk);
	endtask

	task automatic wait_idle();
		stop_words();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_BLOCK_ROWS:     cfg_shadow.block_rows = val[4:0];
			REG_BLOCK_COLS:     cfg_shadow.block_cols = val[4:0];
			REG_SUB_ROWS:       cfg_shadow.sub_rows = val[3:0];
			REG_SUB_COLS:       cfg_shadow.sub_cols = val[3:0];
			REG_INFLATE_ALONG:  cfg_shadow.inflate_along_cells = val[5:0];
			REG_INFLATE_ACROSS: cfg_shadow.inflate_across_cells = val[5:0];
			REG_CLEANABLE:      cfg_shadow.block_cleanable = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_config(input int rows, input int cols, input int sr, input int sc,
			input int along, input int across, input int clean);
		write_reg(REG_BLOCK_ROWS, rows);
		write_reg(REG_BLOCK_COLS, cols);
		write_reg(REG_SUB_ROWS, sr);
		write_reg(REG_SUB_COLS, sc);
		write_reg(REG_INFLATE_ALONG, along);
		write_reg(REG_INFLATE_ACROSS, across);
		write_reg(REG_CLEANABLE, clean);
	endtask

	task automatic test_reset_defaults();
		query_cell(4'd0, 4'd0, 3'd0, 3'd0, 2'd0);
		write_cell(4'd0, 4'd0, 1'b1);
		query_cell(4'd0, 4'd0, 3'd0, 3'd0, 2'd1);
		query_cell(4'd1, 4'd0, 3'd0, 3'd0, 2'd2);
		query_cell(4'd0, 4'd0, 3'd7, 3'd7, 2'd3);
		// outside the 1x1 block but still inside the map
		write_cell(4'd3, 4'd3, 1'b1);
	endtask

	task automatic test_status_order();
		wait_idle();
		apply_config(16, 16, 8, 8, 2, 1, 1);
		write_cell(4'd5, 4'd5, 1'b1);
		write_cell(4'd5, 4'd4, 1'b1);
		write_cell(4'd4, 4'd5, 1'b1);
		query_cell(4'd5, 4'd5, 3'd0, 3'd0, 2'd0);
		write_cell(4'd4, 4'd4, 1'b1);
		query_cell(4'd5, 4'd5, 3'd0, 3'd0, 2'd0);
		query_cell(4'd5, 4'd5, 3'd0, 3'd0, 2'd2);
		query_cell(4'd0, 4'd0, 3'd0, 3'd0, 2'd1);
		query_cell(4'd5, 4'd6, 3'd3, 3'd3, 2'd3);
		query_cell(4'd3, 4'd3, 3'd0, 3'd0, 2'd0);
		wait_idle();
		write_reg(REG_CLEANABLE, 0);
		query_cell(4'd5, 4'd5, 3'd0, 3'd0, 2'd0);
	endtask

	task automatic test_geometry_limits();
		wait_idle();
		apply_config(0, 16, 8, 8, 0, 0, 1);
		query_cell(4'd0, 4'd0, 3'd0, 3'd0, 2'd0);
		wait_idle();
		apply_config(31, 17, 15, 9, 0, 0, 1);
		write_cell(4'd15, 4'd15, 1'b1);
		query_cell(4'd15, 4'd15, 3'd7, 3'd7, 2'd1);
		wait_idle();
		apply_config(4, 2, 3, 5, 1, 0, 1);
		query_cell(4'd1, 4'd1, 3'd5, 3'd0, 2'd2);
		query_cell(4'd1, 4'd2, 3'd0, 3'd0, 2'd3);
	endtask

	task automatic test_full_window();
		int r, c;
		logic [3:0] hr, hc;
		wait_idle();
		apply_config(16, 16, 8, 8, 63, 63, 1);
		for (r = 0; r < 16; r++)
			for (c = 0; c < 16; c++)
				write_cell(4'(r), 4'(c), 1'b1);
		for (r = 0; r < 4; r++) begin
			query_cell(4'd7, 4'd7, 3'd7, 3'd7, 2'(r));
			query_cell(4'd8, 4'd8, 3'd0, 3'd0, 2'(r));
		end
		query_cell(4'd7, 4'd7, 3'd6, 3'd7, 2'd0);
		hr = 4'($urandom);
		hc = 4'($urandom);
		write_cell(hr, hc, 1'b0);
		query_cell(4'd8, 4'd8, 3'd0, 3'd0, 2'd0);
		write_cell(hr, hc, 1'b1);
	endtask

	task automatic test_random_phases();
		int ph, i, rows, cols, sr, sc, along, across, clean, er, ec, esr, esc;
		for (ph = 0; ph < 12; ph++) begin
			wait_idle();
			case (ph)
				0: apply_config(16, 16, 8, 8, 1, 2, 1);
				1: apply_config(1, 1, 1, 1, 0, 0, 1);
				2: apply_config(16, 16, 1, 1, 63, 0, 1);
				default: begin
					rows = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
					cols = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
					if ($urandom_range(19) == 0)
						rows = $urandom_range(1) ? 0 : $urandom_range(17, 31);
					if ($urandom_range(19) == 0)
						cols = $urandom_range(1) ? 0 : $urandom_range(17, 31);
					sr = ($urandom_range(19) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
					sc = ($urandom_range(19) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
					along = ($urandom_range(4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
					across = ($urandom_range(4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
					clean = ($urandom_range(9) == 0) ? 0 : 1;
					apply_config(rows, cols, sr, sc, along, across, clean);
				end
			endcase
			er = capped(int'(cfg_shadow.block_rows), DEF_MAX_BLOCK_ROWS);
			ec = capped(int'(cfg_shadow.block_cols), DEF_MAX_BLOCK_COLS);
			esr = capped(int'(cfg_shadow.sub_rows), int'(MAX_SUB_CELLS));
			esc = capped(int'(cfg_shadow.sub_cols), int'(MAX_SUB_CELLS));
			if (er == 0) er = 16;
			if (ec == 0) ec = 16;
			if (esr == 0) esr = 8;
			if (esc == 0) esc = 8;
			no_idle = (ph == 4 || ph == 5);
			for (i = 0; i < 18; i++) begin
				if (i == 9) begin
					// hold off until every pending status is back
					stop_words();
					drain_results();
				end
				case ($urandom_range(9))
					0: send_word(1'($urandom), 4'($urandom), 4'($urandom), 1'($urandom),
						3'($urandom), 3'($urandom), 2'($urandom));
					1, 2, 3, 4:
						write_cell(4'($urandom_range(er - 1)), 4'($urandom_range(ec - 1)),
							($urandom_range(9) != 0));
					default:
						if ($urandom_range(9) == 0)
							query_cell(4'($urandom), 4'($urandom), 3'($urandom),
								3'($urandom), 2'($urandom));
						else
							query_cell(4'($urandom_range(er - 1)), 4'($urandom_range(ec - 1)),
								3'($urandom_range(esr - 1)), 3'($urandom_range(esc - 1)),
								2'($urandom));
				endcase
			end
			no_idle = 1'b0;
		end
	endtask

	always @(posedge clk) begin : check_status
		query_t head;
		if (arst_n && done) begin
			if (pending_status.size() == 0) begin
				$display("%0t: status %0d with no query pending", $time, status);
				failures++;
			end else begin
				head = pending_status.pop_front();
				status_seen[head.status]++;
				if (status !== head.status) begin
					$display("%0t: cell (%0d,%0d) sub (%0d,%0d) heading %0d: expected %0d, got %0d",
						$time, head.cr, head.cc, head.ir, head.ic, head.hd, head.status, status);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		failures = 0;
		cycle_count = 0;
		writes_sent = 0;
		queries_sent = 0;
		no_idle = 1'b0;
		foreach (status_seen[s]) status_seen[s] = 0;
		foreach (occupancy[r, c]) occupancy[r][c] = 1'b0;
		cfg_shadow = '{block_rows: 5'd1, block_cols: 5'd1, sub_rows: 4'd1, sub_cols: 4'd1,
			inflate_along_cells: 6'd0, inflate_across_cells: 6'd0, block_cleanable: 1'b1};
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		start      <= 1'b0;
		kind       <= 1'b0;
		coarse_row <= '0;
		coarse_col <= '0;
		present    <= 1'b0;
		fine_row   <= '0;
		fine_col   <= '0;
		heading    <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_status_order();
		test_geometry_limits();
		test_full_window();
		test_random_phases();

		stop_words();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d write words and %0d queries over varied geometry and inflation",
			writes_sent, queries_sent);
		$display("Statuses free/obstacle/no cell/boundary/no inflation/unknown: %0d/%0d/%0d/%0d/%0d/%0d",
			status_seen[ST_FREE], status_seen[ST_OBSTACLE], status_seen[ST_MISSING_CELL],
			status_seen[ST_BOUNDARY], status_seen[ST_MISSING_INFLATION], status_seen[ST_UNKNOWN]);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/gti_pkg.sv
rtl/gti_ram.sv
rtl/gti_cfg.sv
rtl/gti_seq.sv
rtl/grid_traversability_inflation_unit.sv
tb/sv/grid_traversability_inflation_unit_test.sv
